@@ sv/bounded_set_span_tracker_assert.svh @@
// Assertion macros for the bounded set span tracker.
`ifndef BOUNDED_SET_SPAN_TRACKER_ASSERT_SVH
`define BOUNDED_SET_SPAN_TRACKER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/bsst_pkg.sv @@
// Package: beat types, opcodes, status codes and sizes for the span tracker.
package bsst_pkg;

   localparam int OP_W    = 2;
   localparam int VAL_W   = 31;
   localparam int CAP_W   = 11;
   localparam int ST_W    = 2;
   localparam int CNT_W   = 11;

   localparam int DEFAULT_MAX_ENTRIES = 1024;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_ERROR = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [VAL_W-1:0] value;
      logic [CAP_W-1:0] fill_target;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [VAL_W-1:0] longest_span;
      logic [VAL_W-1:0] shortest_span;
      logic [CNT_W-1:0] stored_count;
   } rsp_type;

endpackage

@@ sv/bounded_set_span_tracker.sv @@
// Top level: sorted bounded store with add, fill and span query.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_data  (bsst_pkg::req_type)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_data  (bsst_pkg::rsp_type)
//   csr     | in        | csr_wr_en              | csr_wr_data (capacity)
//
// One item at a time; req_stall is high from accept until the result is loaded.
// Add: each stored entry above the new value is read and rewritten one place higher,
// then the value goes into the gap left. Fill: one add per inserted value.
// Query: one store read per entry, each neighbor gap taken by the shared subtractor.
// Reset clears count and capacity; store contents need no clearing.
// A result waiting on rsp_stall does not block the next accept.
module bounded_set_span_tracker
   import bsst_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int KW = (CW > CAP_W) ? CW : CAP_W;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_FILL_CHK  = 3'd1;
   localparam logic [2:0] S_INS_START = 3'd2;
   localparam logic [2:0] S_INS_CMP   = 3'd3;
   localparam logic [2:0] S_INS_PUT   = 3'd4;
   localparam logic [2:0] S_Q_RUN     = 3'd5;
   localparam logic [2:0] S_Q_FIN     = 3'd6;
   localparam logic [2:0] S_DONE      = 3'd7;

   logic [VAL_W-1:0] store_mem [MAX_ENTRIES];
   logic [VAL_W-1:0] rd_data_ff;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [VAL_W-1:0] wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CAP_W-1:0] capacity_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             dv_ff, dv_in;

   logic [OP_W-1:0]  op_ff, op_in;
   logic [VAL_W-1:0] v_ff, v_in;
   logic [CAP_W-1:0] target_ff, target_in;
   logic [ST_W-1:0]  status_ff, status_in;
   logic [VAL_W-1:0] longest_ff, longest_in;
   logic [VAL_W-1:0] min_ff, min_in;
   logic [VAL_W-1:0] first_ff, first_in;
   logic [VAL_W-1:0] prev_ff, prev_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic [CW-1:0]    proc_idx_ff, proc_idx_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [KW-1:0]    cap_ext, cap_eff, count_ext, target_ext;
   logic [VAL_W-1:0] sub_a, sub_b;
   logic [VAL_W:0]   diff;
   logic             borrow;
   logic             accept;
   logic             rsp_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign cap_ext    = KW'(capacity_ff);
   assign cap_eff    = (cap_ext > KW'(MAX_ENTRIES)) ? KW'(MAX_ENTRIES) : cap_ext;
   assign count_ext  = KW'(count_ff);
   assign target_ext = KW'(target_ff);

   // shared subtractor: insert compare, neighbor gap, and max minus min
   always_comb begin
      case (state_ff)
         S_INS_CMP: begin
            sub_a = v_ff;
            sub_b = rd_data_ff;
         end
         S_Q_FIN: begin
            sub_a = prev_ff;
            sub_b = first_ff;
         end
         default: begin
            sub_a = rd_data_ff;
            sub_b = prev_ff;
         end
      endcase
   end

   assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow = diff[VAL_W];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      v_in         = v_ff;
      target_in    = target_ff;
      status_in    = status_ff;
      longest_in   = longest_ff;
      min_in       = min_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      pos_in       = pos_ff;
      rd_idx_in    = rd_idx_ff;
      proc_idx_in  = proc_idx_ff;
      dv_in        = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = v_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_data.opcode;
               v_in       = req_data.value;
               target_in  = req_data.fill_target;
               status_in  = ST_OK;
               longest_in = '0;
               min_in     = '0;
               case (req_data.opcode)
                  OP_ADD: begin
                     if (count_ext < cap_eff) begin
                        state_in = S_INS_START;
                     end else begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end
                  end
                  OP_FILL: begin
                     if (capacity_ff == '0) begin
                        status_in = ST_ERROR;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_FILL_CHK;
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff < CW'(2)) begin
                        status_in = ST_ERROR;
                        state_in  = S_DONE;
                     end else begin
                        rd_idx_in   = '0;
                        proc_idx_in = '0;
                        state_in    = S_Q_RUN;
                     end
                  end
                  default: begin
                     status_in = ST_ERROR;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_FILL_CHK: begin
            if (count_ext < target_ext && count_ext < cap_eff) begin
               v_in     = VAL_W'(count_ff) + VAL_W'(1);
               state_in = S_INS_START;
            end else begin
               state_in = S_DONE;
            end
         end
         S_INS_START: begin
            if (count_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               count_in = count_ff + CW'(1);
               state_in = (op_ff == OP_FILL) ? S_FILL_CHK : S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(count_ff - CW'(1));
               pos_in   = AW'(count_ff);
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            // rd_data_ff holds entry pos-1; shift it up while it exceeds the new value
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (borrow) begin
               wr_data = rd_data_ff;
               pos_in  = pos_ff - AW'(1);
               if (pos_ff == AW'(1)) begin
                  state_in = S_INS_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff - AW'(2);
               end
            end else begin
               count_in = count_ff + CW'(1);
               state_in = (op_ff == OP_FILL) ? S_FILL_CHK : S_DONE;
            end
         end
         S_INS_PUT: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = (op_ff == OP_FILL) ? S_FILL_CHK : S_DONE;
         end
         S_Q_RUN: begin
            if (rd_idx_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_addr   = rd_idx_ff[AW-1:0];
               rd_idx_in = rd_idx_ff + CW'(1);
               dv_in     = 1'b1;
            end
            if (dv_ff) begin
               if (proc_idx_ff == '0) begin
                  first_in = rd_data_ff;
               end else if (proc_idx_ff == CW'(1) || diff[VAL_W-1:0] < min_ff) begin
                  min_in = diff[VAL_W-1:0];
               end
               prev_in     = rd_data_ff;
               proc_idx_in = proc_idx_ff + CW'(1);
               if (proc_idx_ff + CW'(1) == count_ff) begin
                  state_in = S_Q_FIN;
               end
            end
         end
         S_Q_FIN: begin
            longest_in = diff[VAL_W-1:0];
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_data_in.status        = status_ff;
               rsp_data_in.longest_span  = longest_ff;
               rsp_data_in.shortest_span = min_ff;
               rsp_data_in.stored_count  = CNT_W'(count_ff);
               rsp_valid_in              = 1'b1;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         capacity_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff        <= dv_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      v_ff        <= v_in;
      target_ff   <= target_in;
      status_ff   <= status_in;
      longest_ff  <= longest_in;
      min_ff      <= min_in;
      first_ff    <= first_in;
      prev_ff     <= prev_in;
      pos_ff      <= pos_in;
      rd_idx_ff   <= rd_idx_in;
      proc_idx_ff <= proc_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

`include "bounded_set_span_tracker_assert.svh"

   `BSST_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(MAX_ENTRIES), "count exceeds store depth")
   `BSST_ASSERT_NOW(a_cmp_pos, state_ff == S_INS_CMP, pos_ff != '0, "insert compare at position zero")
   `BSST_ASSERT_NEXT(a_count_step, 1'b1, count_ff == $past(count_ff) || count_ff == $past(count_ff) + CW'(1), "count moved by more than one")
   `BSST_ASSERT_NOW(a_span_order, rsp_valid_ff && rsp_data_ff.status == ST_OK, rsp_data_ff.shortest_span <= rsp_data_ff.longest_span, "shortest span above longest span")

endmodule

@@ tb/sv/bsst_span_checker.sv @@
// Checker for the span tracker: tracks the sorted store, predicts each result beat and compares.
module bsst_span_checker
   import bsst_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   output int               failures,
   output int               results_done,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 100;

   logic [VAL_W-1:0] held_values [MAX_ENTRIES];
   int unsigned      held_count;
   logic [CAP_W-1:0] capacity_reg;
   rsp_type          expected_spans [$];

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (failures < PRINT_LIMIT) begin
         $display("%0t checker: %s: got %0d, expected %0d", $time, what, got, want);
      end
      failures++;
   endtask

   // Callers make sure there is room below MAX_ENTRIES.
   function automatic void insert_value(input logic [VAL_W-1:0] v);
      int unsigned slot;
      slot = held_count;
      while (slot > 0 && held_values[slot-1] > v) begin
         held_values[slot] = held_values[slot-1];
         slot--;
      end
      held_values[slot] = v;
      held_count++;
   endfunction

   function automatic rsp_type predict_span_result(input req_type beat);
      rsp_type          outcome;
      int unsigned      eff_cap;
      int unsigned      idx;
      logic [VAL_W-1:0] gap;
      outcome = '0;
      eff_cap = (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : capacity_reg;
      case (beat.opcode)
         OP_ADD: begin
            if (held_count < eff_cap) begin
               insert_value(beat.value);
            end else begin
               outcome.status = ST_FULL;
            end
         end
         OP_FILL: begin
            // zero capacity is an error; a capacity below the count just inserts nothing
            if (capacity_reg == '0) begin
               outcome.status = ST_ERROR;
            end else begin
               while (held_count < beat.fill_target && held_count < eff_cap) begin
                  insert_value(VAL_W'(held_count + 1));
               end
            end
         end
         OP_QUERY: begin
            if (held_count < 2) begin
               outcome.status = ST_ERROR;
            end else begin
               outcome.longest_span  = held_values[held_count-1] - held_values[0];
               outcome.shortest_span = held_values[1] - held_values[0];
               for (idx = 1; idx + 1 < held_count; idx++) begin
                  gap = held_values[idx+1] - held_values[idx];
                  if (gap < outcome.shortest_span) begin
                     outcome.shortest_span = gap;
                  end
               end
            end
         end
         default: begin
            outcome.status = ST_ERROR;
         end
      endcase
      outcome.stored_count = CNT_W'(held_count);
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held_count   = 0;
         capacity_reg = '0;
         expected_spans.delete();
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            capacity_reg = csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            results_done <= results_done + 1;
            if (expected_spans.size() == 0) begin
               report_mismatch("result beat with nothing pending, status", rsp_data.status, 0);
            end else begin
               want = expected_spans.pop_front();
               if (rsp_data.status !== want.status) begin
                  report_mismatch("status", rsp_data.status, want.status);
               end
               if (rsp_data.longest_span !== want.longest_span) begin
                  report_mismatch("longest_span", rsp_data.longest_span, want.longest_span);
               end
               if (rsp_data.shortest_span !== want.shortest_span) begin
                  report_mismatch("shortest_span", rsp_data.shortest_span, want.shortest_span);
               end
               if (rsp_data.stored_count !== want.stored_count) begin
                  report_mismatch("stored_count", rsp_data.stored_count, want.stored_count);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_span_result(req_data);
            expected_spans.insert(expected_spans.size(), want);
         end
         pending <= expected_spans.size();
      end
   end

endmodule

@@ tb/sv/tb_bounded_set_span_tracker.sv @@
// Testbench top for the span tracker: clock, reset, stimulus, receiver stalls and verdict.
module tb_bounded_set_span_tracker
   import bsst_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              ENTRIES     = DEFAULT_MAX_ENTRIES;
   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam int              HOLD_CYCLES = 300;
   localparam logic [VAL_W-1:0] VAL_MAX    = {VAL_W{1'b1}};

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   req_type          req_data    = '0;
   logic             rsp_stall   = 1'b0;
   logic             csr_wr_en   = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;
   logic             req_stall;
   logic             rsp_valid;
   rsp_type          rsp_data;

   int failures;
   int results_done;
   int pending;
   int items_sent    = 0;
   int burst_left    = 0;
   int hold_requests = 0;
   int holds_taken   = 0;
   int hold_left     = 0;
   int stall_mode    = 0;
   int mode_left     = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   bounded_set_span_tracker #(
      .MAX_ENTRIES(ENTRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   bsst_span_checker #(
      .MAX_ENTRIES(ENTRIES)
   ) span_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .results_done(results_done),
      .pending     (pending)
   );

   // Receiver: long hold-off on request, otherwise a stall mode that changes now and then.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_requests != holds_taken) begin
         holds_taken++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Holds the beat until accepted; keeps valid high within a burst, else drops it for a gap.
   task automatic send_beat(input req_type beat);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4))
            @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      end
   endtask

   task automatic send_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                          input logic [CAP_W-1:0] target);
      req_type beat;
      beat.opcode      = op;
      beat.value       = value;
      beat.fill_target = target;
      send_beat(beat);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (results_done < items_sent) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type random_beat(input int unsigned cap);
      req_type     beat;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         beat.opcode = OP_ADD;
      end else if (pick < 55) begin
         beat.opcode = OP_FILL;
      end else if (pick < 92) begin
         beat.opcode = OP_QUERY;
      end else begin
         beat.opcode = OP_UNUSED;
      end
      // small values make duplicates and tight gaps likely
      case ($urandom_range(0, 3))
         0: beat.value = VAL_W'($urandom_range(0, 31));
         1: beat.value = ($urandom_range(0, 1) == 0) ? VAL_MAX : '0;
         default: beat.value = VAL_W'($urandom);
      endcase
      if ($urandom_range(0, 1) == 0) begin
         beat.fill_target = CAP_W'($urandom_range(0, cap + 4));
      end else begin
         beat.fill_target = CAP_W'($urandom);
      end
      return beat;
   endfunction

   task automatic random_run(input int unsigned cap, input int count);
      repeat (count) send_beat(random_beat(cap));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero capacity: add full, fill error, query error, unused opcode error
      write_capacity(11'd0);
      send_op(OP_ADD, '0, '0);
      send_op(OP_FILL, VAL_MAX, 11'd2047);
      send_op(OP_QUERY, '0, '0);
      send_op(OP_UNUSED, VAL_MAX, 11'd2047);

      write_capacity(11'd5);
      send_op(OP_QUERY, '0, '0);
      send_op(OP_ADD, VAL_MAX, '0);
      send_op(OP_QUERY, '0, '0);
      send_op(OP_ADD, '0, '0);
      send_op(OP_QUERY, '0, '0);
      send_op(OP_ADD, 31'd5, '0);
      send_op(OP_ADD, 31'd5, '0);
      send_op(OP_QUERY, '0, '0);
      send_op(OP_FILL, '0, 11'd1);
      send_op(OP_ADD, 31'd9, '0);
      send_op(OP_ADD, 31'd7, '0);
      send_op(OP_FILL, '0, 11'd2047);
      send_op(OP_UNUSED, '0, '0);

      // capacity below the count already held
      write_capacity(11'd2);
      send_op(OP_ADD, 31'd3, '0);
      send_op(OP_FILL, '0, 11'd100);
      send_op(OP_QUERY, '0, '0);

      write_capacity(11'd12);
      send_op(OP_FILL, '0, 11'd8);
      send_op(OP_FILL, '0, 11'd2047);
      send_op(OP_QUERY, '0, '0);

      write_capacity(11'd40);
      random_run(40, 60);
      hold_requests++;
      random_run(40, 70);

      write_capacity(11'd9);
      random_run(9, 25);

      write_capacity(11'd130);
      random_run(130, 150);

      write_capacity(11'd320);
      random_run(320, 200);

      write_capacity(11'd1024);
      send_op(OP_FILL, '0, 11'd2047);
      send_op(OP_QUERY, '0, '0);
      send_op(OP_ADD, VAL_MAX, '0);

      write_capacity(11'd2047);
      random_run(2047, 20);

      drain_results();
      repeat (1100) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #80ms;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ bounded_set_span_tracker.f @@
+incdir+sv
sv/bsst_pkg.sv
sv/bounded_set_span_tracker.sv
tb/sv/bsst_span_checker.sv
tb/sv/tb_bounded_set_span_tracker.sv
